@@ rtl/fmm_pkg.sv @@
// fmm_pkg: shared types, request codes and float helpers for the matrix multiply engine
// no dependencies
`default_nettype none
package fmm_pkg;
	localparam logic [1:0] REQ_WRITE_A = 2'd0;
	localparam logic [1:0] REQ_WRITE_B = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;
	localparam int unsigned ROW_RESULTS = 64;
	localparam logic [31:0] QNAN = 32'h7FC0_0000;
	localparam logic [31:0] PINF = 32'h7F80_0000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] elem_index;
		logic [5:0]  row_select;
		logic [31:0] elem_bits;
	} req_t;

	typedef struct packed {
		logic [5:0]  col_index;
		logic [31:0] result_bits;
		logic        last_of_row;
		logic        row_error;
	} res_t;

	// operand classification passed between the float stages
	typedef struct packed {
		logic        special;
		logic [31:0] special_val;
		logic        sign;
		logic [9:0]  exp;
		logic [63:0] sig;
	} fpre_t;

	function automatic logic is_nan(input logic [31:0] x);
		return x[30:0] > PINF[30:0];
	endfunction
	function automatic logic is_inf(input logic [31:0] x);
		return x[30:0] == PINF[30:0];
	endfunction
	function automatic logic is_zero(input logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction
endpackage
`default_nettype wire

@@ rtl/fmm_stream_if.sv @@
// fmm_stream_if: valid/ready channel carrying one payload type
// depends on nothing; payload type given as a parameter
`default_nettype none
interface fmm_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/fmm_store.sv @@
// fmm_store: one synchronous single-port-write, one-read matrix memory
// registered read data
`default_nettype none
module fmm_store #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);
	logic [31:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/fmm_round.sv @@
// fmm_round: normalizing round-to-nearest-even packer, iterative shift search
// depends on fmm_pkg
`default_nettype none
module fmm_round (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        sign,
	input  wire logic [11:0] exp,
	input  wire logic [63:0] sig,
	output logic             done,
	output logic [31:0]      result
);
	import fmm_pkg::*;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NORM = 2'd1;
	localparam logic [1:0] ST_PACK = 2'd2;

	logic [1:0]  state_q;
	logic        sign_q;
	logic signed [11:0] exp_q;
	logic [63:0] sig_q;
	logic [63:0] den_sig;
	logic [5:0]  den_sh;
	logic        den_sticky;
	logic [24:0] keep;
	logic [38:0] rem;
	logic [24:0] keep_r;
	logic [32:0] bits;

	always_comb begin
		den_sh = 6'd0;
		if (exp_q < 12'sd1) begin
			den_sh = (exp_q < -12'sd61) ? 6'd63 : 6'(12'sd1 - exp_q);
		end
		den_sticky = 1'b0;
		for (int i = 0; i < 64; i++) begin
			if (i < int'(den_sh) && sig_q[i]) begin
				den_sticky = 1'b1;
			end
		end
		den_sig = (sig_q >> den_sh) | {63'd0, den_sticky};
		keep = {1'b0, den_sig[62:39]};
		rem = den_sig[38:0];
		keep_r = keep;
		if (rem > {1'b1, 38'd0} || (rem == {1'b1, 38'd0} && keep[0])) begin
			keep_r = keep + 25'd1;
		end
		if (exp_q < 12'sd1) begin
			bits = {33'd0} + 33'(keep_r);
		end else begin
			bits = {(10'(exp_q) - 10'd1), 23'd0} + 33'(keep_r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (sig_q[63] || sig_q[62]) begin
						state_q <= ST_PACK;
					end
				end
				ST_PACK: begin
					state_q <= ST_IDLE;
					done <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sign_q <= sign;
				exp_q <= $signed(exp);
				sig_q <= sig;
			end
			ST_NORM: begin
				if (sig_q[63]) begin
					sig_q <= {1'b0, sig_q[63:2], sig_q[1] | sig_q[0]};
					exp_q <= exp_q + 12'sd1;
				end else if (!sig_q[62]) begin
					// up to eight places a cycle
					if (sig_q[62:55] == 8'd0) begin
						sig_q <= sig_q << 8;
						exp_q <= exp_q - 12'sd8;
					end else begin
						sig_q <= sig_q << 1;
						exp_q <= exp_q - 12'sd1;
					end
				end
			end
			ST_PACK: begin
				if (exp_q >= 12'sd255 || bits >= 33'(PINF)) begin
					result <= {sign_q, PINF[30:0]};
				end else begin
					result <= {sign_q, bits[30:0]};
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/fmm_fpu.sv @@
// fmm_fpu: multiply then add into accumulator, shared rounding unit
// depends on fmm_pkg, fmm_round
`default_nettype none
module fmm_fpu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [31:0] acc,
	output logic             done,
	output logic [31:0]      sum
);
	import fmm_pkg::*;
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_MWAIT = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_ALIGN = 3'd4;
	localparam logic [2:0] ST_AWAIT = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] a_q, b_q, acc_q, x_q, y_q;
	logic [31:0] prod_next;
	logic [47:0] mprod;
	logic        mul_special;
	logic        r_start, r_done, r_sign;
	logic [11:0] r_exp;
	logic [63:0] r_sig;
	logic [31:0] r_res;
	logic [63:0] al_q, bl_q;
	logic        add_sub_q;
	logic [9:0]  ea_q;
	logic        sa_q;
	logic [8:0]  dshift;
	logic [63:0] bl_sh;
	logic        bl_sticky;
	logic [23:0] ma, mb, mx, my;
	logic [7:0]  exa, exb;

	fmm_round u_round (
		.clk(clk), .arst_n(arst_n), .start(r_start), .sign(r_sign),
		.exp(r_exp), .sig(r_sig), .done(r_done), .result(r_res)
	);

	always_comb begin
		ma = (a_q[30:23] == 8'd0) ? {1'b0, a_q[22:0]} : {1'b1, a_q[22:0]};
		mb = (b_q[30:23] == 8'd0) ? {1'b0, b_q[22:0]} : {1'b1, b_q[22:0]};
		exa = (a_q[30:23] == 8'd0) ? 8'd1 : a_q[30:23];
		exb = (b_q[30:23] == 8'd0) ? 8'd1 : b_q[30:23];
		mprod = ma * mb;
		mul_special = is_nan(a_q) || is_nan(b_q) || is_inf(a_q) || is_inf(b_q)
			|| is_zero(a_q) || is_zero(b_q);
		if (state_q == ST_MWAIT) begin
			prod_next = r_res;
		end else if (is_nan(a_q) || is_nan(b_q)) begin
			prod_next = QNAN;
		end else if (is_inf(a_q) || is_inf(b_q)) begin
			prod_next = (is_zero(a_q) || is_zero(b_q)) ? QNAN
				: {a_q[31] ^ b_q[31], PINF[30:0]};
		end else begin
			prod_next = {a_q[31] ^ b_q[31], 31'd0};
		end
		mx = (x_q[30:23] == 8'd0) ? {1'b0, x_q[22:0]} : {1'b1, x_q[22:0]};
		my = (y_q[30:23] == 8'd0) ? {1'b0, y_q[22:0]} : {1'b1, y_q[22:0]};
		dshift = {1'b0, (x_q[30:23] == 8'd0) ? 8'd1 : x_q[30:23]}
			- {1'b0, (y_q[30:23] == 8'd0) ? 8'd1 : y_q[30:23]};
		bl_sticky = 1'b0;
		for (int i = 0; i < 64; i++) begin
			if ((i < int'(dshift) || dshift > 9'd63) && bl_q[i]) begin
				bl_sticky = 1'b1;
			end
		end
		bl_sh = (dshift > 9'd63) ? 64'd0 : (bl_q >> dshift[5:0]);
		bl_sh[0] = bl_sh[0] | bl_sticky;
		r_start = 1'b0;
		r_sign = 1'b0;
		r_exp = 12'd0;
		r_sig = 64'd0;
		if (state_q == ST_MUL && !mul_special) begin
			r_start = 1'b1;
			r_sign = a_q[31] ^ b_q[31];
			// product exponent ea+eb-111 as 12-bit two's complement
			r_exp = {4'd0, exa} + {4'd0, exb} - 12'd111;
			r_sig = {16'd0, mprod};
		end else if (state_q == ST_ALIGN) begin
			r_start = 1'b1;
			r_sign = sa_q;
			r_exp = {2'b0, ea_q};
			r_sig = add_sub_q ? (al_q - bl_sh) : (al_q + bl_sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_MUL;
				ST_MUL: begin
					if (mul_special) begin
						state_q <= ST_ADD;
					end else begin
						state_q <= ST_MWAIT;
					end
				end
				ST_MWAIT: if (r_done) state_q <= ST_ADD;
				ST_ADD: begin
					if (is_nan(x_q) || is_nan(y_q) || is_inf(x_q) || is_inf(y_q)
						|| is_zero(x_q) || is_zero(y_q) || (x_q[30:0] == y_q[30:0]
						&& x_q[31] != y_q[31])) begin
						state_q <= ST_IDLE;
						done <= 1'b1;
					end else begin
						state_q <= ST_ALIGN;
					end
				end
				ST_ALIGN: state_q <= ST_AWAIT;
				ST_AWAIT: begin
					if (r_done) begin
						state_q <= ST_IDLE;
						done <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			a_q <= a;
			b_q <= b;
			acc_q <= acc;
		end
		if (state_q == ST_ADD) begin
			if (is_nan(x_q) || is_nan(y_q)) begin
				sum <= QNAN;
			end else if (is_inf(x_q) && is_inf(y_q)) begin
				sum <= (x_q[31] == y_q[31]) ? x_q : QNAN;
			end else if (is_inf(x_q)) begin
				sum <= x_q;
			end else if (is_inf(y_q)) begin
				sum <= y_q;
			end else if (is_zero(x_q) && is_zero(y_q)) begin
				sum <= {x_q[31] & y_q[31], 31'd0};
			end else if (is_zero(x_q)) begin
				sum <= y_q;
			end else if (is_zero(y_q)) begin
				sum <= x_q;
			end else if (x_q[30:0] == y_q[30:0] && x_q[31] != y_q[31]) begin
				sum <= 32'd0;
			end
			al_q <= {1'b0, mx, 39'd0};
			bl_q <= {1'b0, my, 39'd0};
			sa_q <= x_q[31];
			add_sub_q <= x_q[31] != y_q[31];
			ea_q <= {2'b0, (x_q[30:23] == 8'd0) ? 8'd1 : x_q[30:23]};
		end
		if (state_q == ST_AWAIT && r_done) begin
			sum <= r_res;
		end
	end

	// order the adder operands by magnitude
	always_ff @(posedge clk) begin
		if ((state_q == ST_MUL && mul_special) || (state_q == ST_MWAIT && r_done)) begin
			if (acc_q[30:0] < prod_next[30:0]) begin
				x_q <= prod_next;
				y_q <= acc_q;
			end else begin
				x_q <= acc_q;
				y_q <= prod_next;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/float_matrix_multiply_engine.sv @@
// Single-precision matrix multiply engine. Write transactions load A or B elements into two
// on-chip memories; a compute transaction streams one row of C, one result per column. Each
// multiply-add runs through one shared float unit, which skips the rounding pass for the
// product when a product operand is zero, infinite or NaN; each step first reads both
// memories (READ, WAIT states). One item is worked at a time. Memories are not cleared at
// reset.
// depends on fmm_pkg, fmm_stream_if, fmm_store, fmm_fpu
`default_nettype none
module float_matrix_multiply_engine #(
	parameter int unsigned MAX_DIM = 64,
	parameter int unsigned STORE_DEPTH = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [6:0]          cfg_data,
	fmm_stream_if.sink               req,
	fmm_stream_if.source             res
);
	import fmm_pkg::*;
	localparam int unsigned AW = $clog2(STORE_DEPTH);
	localparam int unsigned DW = $clog2(MAX_DIM + 1);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_FPU   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [1:0] CFG_ROWS = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;
	localparam logic [1:0] CFG_INNER = 2'd2;
	localparam logic [1:0] CFG_TRANS = 2'd3;

	logic [6:0]  rows_q, cols_q, inner_q;
	logic        trans_q;
	logic [2:0]  state_q;
	logic [DW-1:0] l_dim, m_dim, n_dim;
	logic [DW-1:0] j_q, k_q;
	logic [5:0]  row_q;
	logic [31:0] acc_q;
	logic [AW-1:0] a_addr_q, b_addr_q;
	logic [31:0] a_rd, b_rd;
	logic        fpu_start, fpu_done;
	logic [31:0] fpu_sum;
	logic        out_valid_q;
	res_t        out_q;
	logic        we_a, we_b;

	function automatic logic [DW-1:0] clampd(input logic [6:0] v, input int unsigned hi);
		logic [DW-1:0] r;
		if (v == 7'd0) r = DW'(1);
		else if (32'(v) > hi) r = DW'(hi);
		else r = DW'(v);
		return r;
	endfunction

	assign l_dim = clampd(rows_q, MAX_DIM);
	assign n_dim = clampd(inner_q, MAX_DIM);
	assign m_dim = clampd(cols_q, (MAX_DIM < ROW_RESULTS) ? MAX_DIM : ROW_RESULTS);

	assign req.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign we_a = req.valid && req.ready && req.data.req_type == REQ_WRITE_A;
	assign we_b = req.valid && req.ready && req.data.req_type == REQ_WRITE_B;
	assign res.valid = out_valid_q;
	assign res.data = out_q;
	assign fpu_start = state_q == ST_WAIT;

	fmm_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store_a (
		.clk(clk), .we(we_a), .waddr(AW'(req.data.elem_index)),
		.wdata(req.data.elem_bits), .raddr(a_addr_q), .rdata(a_rd)
	);
	fmm_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store_b (
		.clk(clk), .we(we_b), .waddr(AW'(req.data.elem_index)),
		.wdata(req.data.elem_bits), .raddr(b_addr_q), .rdata(b_rd)
	);
	fmm_fpu u_fpu (
		.clk(clk), .arst_n(arst_n), .start(fpu_start), .a(a_rd), .b(b_rd),
		.acc(acc_q), .done(fpu_done), .sum(fpu_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd1;
			cols_q <= 7'd1;
			inner_q <= 7'd1;
			trans_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS:  rows_q <= cfg_data;
				CFG_COLS:  cols_q <= cfg_data;
				CFG_INNER: inner_q <= cfg_data;
				CFG_TRANS: trans_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready && req.data.req_type == REQ_COMPUTE) begin
						if (DW'(req.data.row_select) >= l_dim
							|| 32'(req.data.row_select) >= MAX_DIM) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_WAIT;
				ST_WAIT: state_q <= ST_FPU;
				ST_FPU: begin
					if (fpu_done) begin
						if (k_q + DW'(1) == n_dim) begin
							state_q <= ST_EMIT;
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_EMIT: begin
					if (res.ready) begin
						state_q <= (j_q + DW'(1) == m_dim) ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				row_q <= req.data.row_select;
				j_q <= '0;
				k_q <= '0;
				acc_q <= 32'd0;
				out_q <= '{col_index: 6'd0, result_bits: 32'd0, last_of_row: 1'b1,
					row_error: 1'b1};
				a_addr_q <= AW'(32'(req.data.row_select) * 32'(n_dim));
				b_addr_q <= '0;
			end
			ST_FPU: begin
				if (fpu_done) begin
					acc_q <= fpu_sum;
					out_q <= '{col_index: 6'(j_q), result_bits: fpu_sum,
						last_of_row: j_q + DW'(1) == m_dim, row_error: 1'b0};
					if (k_q + DW'(1) == n_dim) begin
						k_q <= '0;
					end else begin
						k_q <= k_q + DW'(1);
						a_addr_q <= a_addr_q + AW'(1);
						b_addr_q <= b_addr_q + (trans_q ? AW'(1) : AW'(m_dim));
					end
				end
			end
			ST_EMIT: begin
				if (res.ready) begin
					j_q <= j_q + DW'(1);
					acc_q <= 32'd0;
					a_addr_q <= AW'(32'(row_q) * 32'(n_dim));
					b_addr_q <= trans_q ? AW'(32'(j_q + DW'(1)) * 32'(n_dim))
						: AW'(j_q + DW'(1));
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ tb/float_matrix_multiply_engine_tb.sv @@
// float_matrix_multiply_engine_tb: drives write and compute transactions, predicts each row of C
// with a bit-exact single-precision multiply-add model and checks every result in order
// depends on fmm_pkg, fmm_stream_if and float_matrix_multiply_engine
`default_nettype none
module float_matrix_multiply_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fmm_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_INNER = 2'd2;
	localparam logic [1:0] REG_TRANSPOSED = 2'd3;
	localparam int unsigned DEPTH = 4096;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	class row_scoreboard;
		bit [31:0] mem_a [DEPTH];
		bit [31:0] mem_b [DEPTH];
		bit [6:0] rows_r, cols_r, inner_r;
		bit transposed_r;
		res_t expected_q [$];
		int errors;

		function new();
			rows_r = 1;
			cols_r = 1;
			inner_r = 1;
			transposed_r = 0;
			errors = 0;
		endfunction

		function int unsigned dim(bit [6:0] v);
			if (v == 0) return 1;
			return (v > 64) ? 64 : v;
		endfunction

		function void set_reg(logic [1:0] idx, logic [6:0] v);
			case (idx)
				REG_ROWS: rows_r = v;
				REG_COLS: cols_r = v;
				REG_INNER: inner_r = v;
				REG_TRANSPOSED: transposed_r = v[0];
			endcase
		endfunction

		function bit is_nan_f(bit [31:0] x);
			return x[30:0] > 31'h7F800000;
		endfunction
		function bit is_inf_f(bit [31:0] x);
			return x[30:0] == 31'h7F800000;
		endfunction
		function bit is_zero_f(bit [31:0] x);
			return x[30:0] == 31'd0;
		endfunction

		function bit [63:0] jam(bit [63:0] s, int d);
			if (d <= 0) return s;
			if (d >= 63) return (s != 0) ? 64'd1 : 64'd0;
			return (s >> d) | (((s & ((64'd1 << d) - 1)) != 0) ? 64'd1 : 64'd0);
		endfunction

		function bit [31:0] pack_round(bit [31:0] sign, int e, bit [63:0] sig);
			bit [63:0] keep, rem, bits;
			if (sig[63]) begin
				sig = jam(sig, 1);
				e++;
			end
			while (!sig[62]) begin
				sig = sig << 1;
				e--;
			end
			if (e < 1) begin
				sig = jam(sig, 1 - e);
				e = 1;
			end
			if (e >= 255) return sign | PINF;
			keep = sig >> 39;
			rem = sig & ((64'd1 << 39) - 1);
			if (rem > (64'd1 << 38) || (rem == (64'd1 << 38) && keep[0])) keep++;
			bits = (64'(e - 1) << 23) + keep;
			if (bits >= 64'h7F800000) return sign | PINF;
			return sign | bits[31:0];
		endfunction

		function void split(bit [31:0] x, output int e, output bit [63:0] m);
			m = {41'd0, x[22:0]};
			if (x[30:23] == 0) e = 1;
			else begin
				e = int'(x[30:23]);
				m[23] = 1'b1;
			end
		endfunction

		function bit [31:0] fp_mul(bit [31:0] a, bit [31:0] b);
			bit [31:0] s;
			int ea, eb;
			bit [63:0] ma, mb;
			s = (a ^ b) & 32'h80000000;
			if (is_nan_f(a) || is_nan_f(b)) return QNAN;
			if (is_inf_f(a) || is_inf_f(b)) begin
				if (is_zero_f(a) || is_zero_f(b)) return QNAN;
				return s | PINF;
			end
			if (is_zero_f(a) || is_zero_f(b)) return s;
			split(a, ea, ma);
			split(b, eb, mb);
			return pack_round(s, ea + eb - 111, ma * mb);
		endfunction

		function bit [31:0] fp_add(bit [31:0] a, bit [31:0] b);
			bit [31:0] sa, sb, t;
			int ea, eb;
			bit [63:0] ma, mb;
			sa = a & 32'h80000000;
			sb = b & 32'h80000000;
			if (is_nan_f(a) || is_nan_f(b)) return QNAN;
			if (is_inf_f(a) && is_inf_f(b)) return (sa == sb) ? a : QNAN;
			if (is_inf_f(a)) return a;
			if (is_inf_f(b)) return b;
			if (is_zero_f(a) && is_zero_f(b)) return sa & sb;
			if (is_zero_f(a)) return b;
			if (is_zero_f(b)) return a;
			if (a[30:0] < b[30:0]) begin
				t = a; a = b; b = t;
				t = sa; sa = sb; sb = t;
			end
			split(a, ea, ma);
			split(b, eb, mb);
			ma = ma << 39;
			mb = jam(mb << 39, ea - eb);
			if (sa == sb) return pack_round(sa, ea, ma + mb);
			if (ma == mb) return 32'd0;
			return pack_round(sa, ea, ma - mb);
		endfunction

		function void note_request(req_t r);
			int unsigned l, m, n, ai, bi;
			bit [31:0] sum;
			res_t e;
			case (r.req_type)
				REQ_WRITE_A: mem_a[r.elem_index] = r.elem_bits;
				REQ_WRITE_B: mem_b[r.elem_index] = r.elem_bits;
				REQ_COMPUTE: begin
					l = dim(rows_r);
					m = dim(cols_r);
					n = dim(inner_r);
					if (r.row_select >= l) begin
						e.col_index = 6'd0;
						e.result_bits = 32'd0;
						e.last_of_row = 1'b1;
						e.row_error = 1'b1;
						expected_q.push_back(e);
					end else begin
						for (int j = 0; j < m; j++) begin
							sum = 32'd0;
							for (int k = 0; k < n; k++) begin
								ai = (k + r.row_select * n) % DEPTH;
								bi = (transposed_r ? (k + j * n) : (j + k * m)) % DEPTH;
								sum = fp_add(sum, fp_mul(mem_a[ai], mem_b[bi]));
							end
							e.col_index = 6'(j);
							e.result_bits = sum;
							e.last_of_row = (j + 1 == m);
							e.row_error = 1'b0;
							expected_q.push_back(e);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.col_index !== e.col_index || got.result_bits !== e.result_bits ||
					got.last_of_row !== e.last_of_row || got.row_error !== e.row_error) begin
				$display("%0t: mismatch expected %p actual %p", $time, e, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;
	fmm_stream_if #(.T(req_t)) req_if ();
	fmm_stream_if #(.T(res_t)) res_if ();

	row_scoreboard sb = new();
	idle_mode_t idle_mode = IDLE_NONE;
	bit a_set [DEPTH];
	bit b_set [DEPTH];
	int phase_items;

	float_matrix_multiply_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_if),
		.res(res_if)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && req_if.valid && req_if.ready) sb.note_request(req_if.data);
		if (arst_n && res_if.valid && res_if.ready) sb.check_result(res_if.data);
	end

	initial begin
		res_if.ready = 0;
		forever begin
			@(negedge clk);
			if (idle_mode == IDLE_RECV)
				res_if.ready = arst_n && ($urandom_range(99) >= 54);
			else if (idle_mode == IDLE_BOTH)
				res_if.ready = arst_n && ($urandom_range(99) >= 15);
			else
				res_if.ready = arst_n;
		end
	end

	function bit [31:0] rand_float();
		bit s;
		s = 1'($urandom_range(1));
		case ($urandom_range(11))
			0, 1, 2, 3, 4: return {s, 8'(124 + $urandom_range(6)), 23'($urandom)};
			5: return $urandom;
			6: return {s, 8'd0, 23'($urandom)};
			7: return {s, 31'd0};
			8: return {s, 8'hFF, 23'd0};
			9: return {s, 8'hFF, 23'($urandom) | 23'd1};
			10: return {s, 8'(245 + $urandom_range(9)), 23'($urandom)};
			default: return {s, 8'($urandom_range(1, 10)), 23'($urandom)};
		endcase
	endfunction

	task automatic send(logic [1:0] kind, logic [11:0] idx, logic [5:0] row, logic [31:0] val);
		req_t r;
		int stall;
		r.req_type = kind;
		r.elem_index = idx;
		r.row_select = row;
		r.elem_bits = val;
		stall = (idle_mode == IDLE_SEND) ? 54 : (idle_mode == IDLE_BOTH) ? 15 : 0;
		while ($urandom_range(99) < stall) @(negedge clk);
		req_if.valid = 1;
		req_if.data = r;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
		req_if.valid = 0;
		if (kind == REQ_WRITE_A) a_set[idx] = 1;
		if (kind == REQ_WRITE_B) b_set[idx] = 1;
		if (kind != REQ_UNUSED) phase_items++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] v);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		sb.set_reg(idx, v);
		cfg_we = 0;
	endtask

	task automatic drain();
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic compute(logic [5:0] row);
		send(REQ_COMPUTE, 12'($urandom), row, $urandom);
	endtask

	// writes this row's operands that are still unset (and some A operands again at random), then asks for the row
	task automatic good_row(logic [5:0] row);
		int unsigned m, n, ai, bi;
		m = sb.dim(sb.cols_r);
		n = sb.dim(sb.inner_r);
		for (int k = 0; k < n; k++) begin
			ai = (k + row * n) % DEPTH;
			if (!a_set[ai] || $urandom_range(3) == 0)
				send(REQ_WRITE_A, 12'(ai), 6'($urandom), rand_float());
		end
		for (int j = 0; j < m; j++)
			for (int k = 0; k < n; k++) begin
				bi = (sb.transposed_r ? (k + j * n) : (j + k * m)) % DEPTH;
				if (!b_set[bi]) send(REQ_WRITE_B, 12'(bi), 6'($urandom), rand_float());
			end
		compute(row);
	endtask

	task automatic two_by_two(bit [31:0] a0, bit [31:0] a1, bit [31:0] b0, bit [31:0] b1,
			bit [31:0] b2, bit [31:0] b3);
		send(REQ_WRITE_A, 12'd0, 6'd0, a0);
		send(REQ_WRITE_A, 12'd1, 6'd0, a1);
		send(REQ_WRITE_B, 12'd0, 6'd0, b0);
		send(REQ_WRITE_B, 12'd1, 6'd0, b1);
		send(REQ_WRITE_B, 12'd2, 6'd0, b2);
		send(REQ_WRITE_B, 12'd3, 6'd0, b3);
		compute(6'd0);
	endtask

	initial begin
		int rows_p [7] = '{1, 2, 3, 64, 5, 0, 4};
		int cols_p [7] = '{1, 2, 4, 64, 1, 127, 3};
		int inner_p [7] = '{1, 2, 3, 1, 20, 0, 5};
		int tr_p [7] = '{0, 1, 0, 1, 0, 0, 1};
		idle_mode_t mode_p [7] = '{IDLE_NONE, IDLE_NONE, IDLE_NONE, IDLE_SEND, IDLE_RECV,
			IDLE_BOTH, IDLE_BOTH};
		int roll, l;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		req_if.valid = 0;
		req_if.data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		for (int p = 0; p < 7; p++) begin
			if (p > 0) begin
				drain();
				write_reg(REG_ROWS, 7'(rows_p[p]));
				write_reg(REG_COLS, 7'(cols_p[p]));
				write_reg(REG_INNER, 7'(inner_p[p]));
				write_reg(REG_TRANSPOSED, 7'(tr_p[p]));
			end
			idle_mode = mode_p[p];
			phase_items = 0;
			if (p == 0) begin
				send(REQ_WRITE_A, 12'd0, 6'h3F, 32'h7F7FFFFF);
				send(REQ_WRITE_B, 12'd0, 6'd0, 32'h40000000);
				compute(6'd0);
				compute(6'h3F);
				send(REQ_UNUSED, 12'hFFF, 6'h3F, 32'hFFFFFFFF);
				send(REQ_WRITE_A, 12'hFFF, 6'h3F, 32'hFFFFFFFF);
			end else if (p == 1) begin
				two_by_two(PINF, 32'hFF800000, 32'h00000000, 32'h3F800000,
					32'h3F800000, 32'h3F800000);
				two_by_two(32'h3F800000, 32'hBF800000, 32'h3F800000, 32'h3F800000,
					32'h80000000, 32'h00000000);
				two_by_two(32'h00800000, 32'h00000001, 32'h3F000000, 32'h3F800000,
					32'h7FC00001, 32'h3F800000);
			end else begin
				while (phase_items < 10) begin
					l = int'(sb.dim(sb.rows_r));
					roll = $urandom_range(99);
					if (roll < 15)
						send($urandom_range(1) ? REQ_WRITE_B : REQ_WRITE_A, 12'($urandom),
							6'($urandom), rand_float());
					else if (roll < 25 && l < 64)
						compute(6'($urandom_range(63, l)));
					else if (roll < 30)
						send(REQ_UNUSED, 12'($urandom), 6'($urandom), $urandom);
					else
						good_row(6'($urandom_range(l - 1)));
				end
			end
		end
		drain();
		repeat (200) @(negedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
